// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is active.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define AST_NEVER(lbl, cond, msg) \
  `AST_CLK(lbl, !(cond), msg)

`endif

// File: rtl/bdeq_pkg.sv
// Shared constants, types and index helpers for the bounded deque.
package bdeq_pkg;

  localparam int DEPTH  = 1024;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 11;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_REAR  = 2'd1,
    OP_DEL_FRONT = 2'd2,
    OP_DEL_REAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } bdeq_mem_req_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] rear_value;
  } bdeq_status_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

endpackage

// File: rtl/bounded_double_ended_queue.sv
// Top level of the bounded deque: request handshake, result staging and output register.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall  in_op, in_data_value
//   out_     out  out_valid/ out_stall out_ok, out_front_value, out_rear_value,
//                                      out_is_empty, out_is_full
//   cfg_     in   cfg_wr_en            cfg_wr_data (capacity)
//
// One request per cycle while in_stall is low; each result passes the staging register
// then the output register; staging waits on the registered memory read of a delete.
// Synchronous active-low reset empties the queue and sets capacity to 1024.
// in_stall rises only while a staged result waits behind a stalled output register.
module bounded_double_ended_queue
  import bdeq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CAP_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic signed [DATA_W-1:0] in_data_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_rear_value,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  bdeq_mem_req_t     mem_req;
  bdeq_status_t      status;
  logic [DATA_W-1:0] rd_data;
  logic              acc, ok, mid_move;
  logic              mid_valid_r, mid_ok_r;
  logic              out_valid_r, out_ok_r, out_empty_r, out_full_r;
  logic [DATA_W-1:0] out_front_r, out_rear_r;

  assign mid_move = mid_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = mid_valid_r && out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  bdeq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .op          (in_op),
    .data        (in_data_value),
    .rd_data     (rd_data),
    .mem_req     (mem_req),
    .ok          (ok),
    .status      (status)
  );

  bdeq_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        mid_valid_r <= 1'b1;
      end else if (mid_move) begin
        mid_valid_r <= 1'b0;
      end
      if (mid_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mid_ok_r <= ok;
    end
    if (mid_move) begin
      out_ok_r    <= mid_ok_r;
      out_empty_r <= status.empty;
      out_full_r  <= status.full;
      out_front_r <= status.front_value;
      out_rear_r  <= status.rear_value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

endmodule

// File: rtl/bdeq_store.sv
// Entry memory: one write port, one read port with registered read data.
module bdeq_store
  import bdeq_pkg::*;
(
  input  logic                clk,
  input  bdeq_mem_req_t       req,
  output logic [DATA_W-1:0]   rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/bdeq_ctrl.sv
// Deque control: indices, occupancy, capacity and cached end values.
module bdeq_ctrl
  import bdeq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CAP_W-1:0]   cfg_wr_data,
  input  logic               acc,
  input  logic [1:0]         op,
  input  logic [DATA_W-1:0]  data,
  input  logic [DATA_W-1:0]  rd_data,
  output bdeq_mem_req_t      mem_req,
  output logic               ok,
  output bdeq_status_t       status
);

  logic [CAP_W-1:0]  cap_r;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [IDX_W-1:0]  rear_r, rear_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              fpend_r, fpend_nxt;
  logic              rpend_r, rpend_nxt;
  logic [DATA_W-1:0] fval_r, fval_nxt;
  logic [DATA_W-1:0] rval_r, rval_nxt;
  logic [DATA_W-1:0] fval_eff, rval_eff;
  logic [CMP_W-1:0]  eff_cap, cap_ext, cnt_ext;
  logic              is_ins, ins_ok, del_ok;

  // a delete leaves its new end value in the read register until it is cached
  assign fval_eff = fpend_r ? rd_data : fval_r;
  assign rval_eff = rpend_r ? rd_data : rval_r;

  assign cap_ext = CMP_W'(cap_r);
  assign cnt_ext = CMP_W'(cnt_r);
  assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;

  assign is_ins = (op_t'(op) == OP_INS_FRONT) || (op_t'(op) == OP_INS_REAR);
  assign ins_ok = cnt_ext < eff_cap;
  assign del_ok = cnt_r != '0;

  always_comb begin
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    cnt_nxt       = cnt_r;
    fpend_nxt     = 1'b0;
    rpend_nxt     = 1'b0;
    fval_nxt      = fval_eff;
    rval_nxt      = rval_eff;
    ok            = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = front_r;
    mem_req.wdata = data;
    mem_req.re    = 1'b0;
    mem_req.raddr = front_r;
    if (acc) begin
      if (is_ins) begin
        if (ins_ok) begin
          ok         = 1'b1;
          mem_req.we = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
          if (cnt_r == '0) begin
            rear_nxt      = front_r;
            mem_req.waddr = front_r;
            fval_nxt      = data;
            rval_nxt      = data;
          end else if (op_t'(op) == OP_INS_FRONT) begin
            front_nxt     = idx_dec(front_r);
            mem_req.waddr = front_nxt;
            fval_nxt      = data;
          end else begin
            rear_nxt      = idx_inc(rear_r);
            mem_req.waddr = rear_nxt;
            rval_nxt      = data;
          end
        end
      end else if (del_ok) begin
        ok      = 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          rear_nxt = front_r;
        end else if (op_t'(op) == OP_DEL_FRONT) begin
          front_nxt     = idx_inc(front_r);
          mem_req.re    = 1'b1;
          mem_req.raddr = front_nxt;
          fpend_nxt     = 1'b1;
        end else begin
          rear_nxt      = idx_dec(rear_r);
          mem_req.re    = 1'b1;
          mem_req.raddr = rear_nxt;
          rpend_nxt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      front_r <= '0;
      rear_r  <= '0;
      cnt_r   <= '0;
      fpend_r <= 1'b0;
      rpend_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      cnt_r   <= cnt_nxt;
      fpend_r <= fpend_nxt;
      rpend_r <= rpend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fval_r <= fval_nxt;
    rval_r <= rval_nxt;
  end

  assign status.empty       = cnt_r == '0;
  assign status.full        = cnt_ext >= eff_cap;
  assign status.front_value = (cnt_r == '0) ? '1 : fval_eff;
  assign status.rear_value  = (cnt_r == '0) ? '1 : rval_eff;

endmodule

// File: rtl/bdeq_checker.sv
// Port-level checker for the bounded deque and its bind to the top level.
`include "assert_macros.svh"

module bdeq_checker
  import bdeq_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_ok,
  input logic signed [DATA_W-1:0] out_front_value,
  input logic signed [DATA_W-1:0] out_rear_value,
  input logic                     out_is_empty,
  input logic                     out_is_full
);

  logic                  ends_blank;
  logic                  out_wait;
  logic [2*DATA_W+2:0]   out_bundle;

  assign ends_blank = (out_front_value == '1) && (out_rear_value == '1);
  assign out_wait   = out_valid && out_stall;
  assign out_bundle = {out_ok, out_front_value, out_rear_value, out_is_empty, out_is_full};

  `AST_CLK(a_empty_ends, out_valid && out_is_empty |-> ends_blank, "empty result not all ones")
  `AST_CLK(a_fail_cause, out_valid && !out_ok |-> out_is_full || out_is_empty, "failure w/o cause")
  `AST_NEVER(a_stall_cause, in_stall && !out_wait, "input stalled while output drains")
  `AST_CLK(a_out_hold, out_wait |=> out_valid && $stable(out_bundle), "stalled result changed")

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (.*);
